// ===== src/slfd_pkg.sv =====
// ----------------------------------------------------------------------------
// slfd_pkg
// Types and constants shared by the sensor log deframer modules.
// ----------------------------------------------------------------------------
package slfd_pkg;

  localparam logic [31:0] HDR_LEN      = 32'd64;
  localparam logic [9:0]  FRM_LAST     = 10'd851;
  localparam logic [32:0] FRM_LEN      = 33'd852;
  localparam logic [15:0] HDR_MAGIC    = 16'hCAFE;
  localparam logic [15:0] FRM_MAGIC    = 16'h5A5A;
  localparam logic [9:0]  IMU_START    = 10'd520;
  localparam logic [9:0]  IMU_END      = 10'd840;
  localparam logic [15:0] IMU_SLOTS    = 16'd20;

  typedef enum logic [1:0] {
    KIND_ADC  = 2'd0,
    KIND_IMU  = 2'd1,
    KIND_SUMM = 2'd2
  } kind_t;

  typedef enum logic [0:0] {
    REG_FILE_LENGTH = 1'b0,
    REG_FRAME_LIMIT = 1'b1
  } reg_idx_t;

  // Classified work from the front part to the back part.
  // A summary that lands on a sample's last byte still counts that sample.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] sample_tick;
    logic [15:0] adc_value;
    logic [95:0] imu;
    logic        summ_good;
    logic        adc_extra;
    logic        imu_extra;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sample_tick;
    logic [15:0] adc_value;
    logic [15:0] gyro_x;
    logic [15:0] gyro_y;
    logic [15:0] gyro_z;
    logic [15:0] accel_x;
    logic [15:0] accel_y;
    logic [15:0] accel_z;
    logic [15:0] rate_khz;
    logic [31:0] adc_total;
    logic [31:0] imu_total;
  } result_t;

endpackage

// ===== src/slfd_stream_if.sv =====
// ----------------------------------------------------------------------------
// slfd_stream_if
// Valid/ready channel carrying a parameterized payload.
// ----------------------------------------------------------------------------
interface slfd_stream_if #(parameter type payload_t = logic [7:0]);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/sensor_log_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// sensor_log_frame_deframer_top
// Sensor log deframer: bytes in, ADC/IMU samples and a file summary out.
// ----------------------------------------------------------------------------
// One log byte is taken per clock. Each byte produces at most one result,
// which enters a two-entry queue ahead of a registered output stage, so the
// input keeps flowing while a result waits; input ready drops only when the
// queue is full. A result is written into the queue and then loaded into the
// output register. Program file_length and frame_limit over APB while idle.
module sensor_log_frame_deframer_top (
  input  logic        clk,
  input  logic        rst,
  slfd_stream_if.sink   in_ch,
  slfd_stream_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] file_length, frame_limit;
  logic        in_fire, cmd_valid, can_take;
  slfd_pkg::cmd_t cmd;
  logic [15:0] rate;

  assign pready      = 1'b1;
  assign in_ch.ready = can_take;
  assign in_fire     = in_ch.valid && can_take;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= '0;
      frame_limit <= '0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        slfd_pkg::REG_FILE_LENGTH: file_length <= pwdata;
        slfd_pkg::REG_FRAME_LIMIT: frame_limit <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      slfd_pkg::REG_FILE_LENGTH: prdata = file_length;
      slfd_pkg::REG_FRAME_LIMIT: prdata = frame_limit;
      default: prdata = '0;
    endcase
  end

  slfd_front u_front (
    .clk, .rst, .in_fire,
    .data_byte (in_ch.data),
    .file_length, .frame_limit,
    .cmd_valid, .cmd,
    .header_rate (rate)
  );

  slfd_back u_back (
    .clk, .rst, .cmd_valid (cmd_valid && in_fire), .cmd, .rate,
    .can_take,
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

endmodule

// ===== src/slfd_front.sv =====
// ----------------------------------------------------------------------------
// slfd_front
// Tracks header and frame position, holds partial fields and issues commands.
// ----------------------------------------------------------------------------
module slfd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic [7:0]          data_byte,
  input  logic [31:0]         file_length,
  input  logic [31:0]         frame_limit,
  output logic                cmd_valid,
  output slfd_pkg::cmd_t      cmd,
  output logic [15:0]         header_rate
);

  logic [31:0] byte_position;
  logic [9:0]  frame_byte_index;
  logic        header_good;
  logic        frame_active;
  logic [31:0] frames_done;
  logic        limit_reached;
  logic [15:0] imu_in_frame;
  logic [31:0] tick_base;
  logic [7:0]  held_bytes [15];
  logic [7:0]  adc_idx;

  logic        in_hdr;
  logic [9:0]  rel;
  logic [3:0]  r;
  logic [15:0] slot;
  logic        fits;
  logic        at_end;
  logic        adc_hit;
  logic        imu_hit;

  assign in_hdr = byte_position < slfd_pkg::HDR_LEN;
  assign rel    = frame_byte_index - slfd_pkg::IMU_START;
  assign r      = rel[3:0];
  assign slot   = {10'd0, rel[9:4]};
  assign fits   = ({1'b0, byte_position} + slfd_pkg::FRM_LEN) <= {1'b0, file_length};
  assign at_end = (file_length != 32'd0) && (byte_position == file_length - 32'd1);

  // Last byte of an ADC sample or of a used IMU slot in an active frame
  assign adc_hit = !in_hdr && frame_active && frame_byte_index > 10'd7 &&
                   frame_byte_index < slfd_pkg::IMU_START && frame_byte_index[0];
  assign imu_hit = !in_hdr && frame_active && frame_byte_index >= slfd_pkg::IMU_START &&
                   frame_byte_index < slfd_pkg::IMU_END && r == 4'd15 &&
                   slot < imu_in_frame && slot < slfd_pkg::IMU_SLOTS;

  // Classify the byte and build the command
  always_comb begin
    cmd_valid       = 1'b0;
    cmd             = '0;
    cmd.kind        = slfd_pkg::KIND_ADC;
    cmd.sample_tick = tick_base + {24'd0, adc_idx};
    cmd.adc_value   = {data_byte, held_bytes[0]};
    cmd.imu = {held_bytes[11], held_bytes[10], held_bytes[9], held_bytes[8],
               held_bytes[7], held_bytes[6], held_bytes[5], held_bytes[4],
               held_bytes[3], held_bytes[2], held_bytes[1], held_bytes[0]};
    if (adc_hit) begin
      cmd_valid = 1'b1;
    end else if (imu_hit) begin
      cmd_valid       = 1'b1;
      cmd.kind        = slfd_pkg::KIND_IMU;
      cmd.sample_tick = {data_byte, held_bytes[14], held_bytes[13], held_bytes[12]};
    end
    if (at_end) begin
      cmd_valid      = 1'b1;
      cmd            = '0;
      cmd.kind       = slfd_pkg::KIND_SUMM;
      cmd.summ_good  = (file_length >= slfd_pkg::HDR_LEN) && header_good;
      cmd.adc_extra  = adc_hit;
      cmd.imu_extra  = imu_hit;
    end
  end

  // Advance position and frame state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      frame_byte_index <= '0;
      header_good      <= 1'b0;
      frame_active     <= 1'b0;
      frames_done      <= '0;
      limit_reached    <= 1'b0;
      imu_in_frame     <= '0;
      tick_base        <= '0;
      adc_idx          <= '0;
    end else if (in_fire) begin
      if (byte_position != 32'hFFFF_FFFF) byte_position <= byte_position + 32'd1;
      if (in_hdr) begin
        case (byte_position[5:0])
          6'd0: held_bytes[0] <= data_byte;
          6'd1: header_good <= {data_byte, held_bytes[0]} == slfd_pkg::HDR_MAGIC;
          6'd4: held_bytes[4] <= data_byte;
          default: ;
        endcase
      end else begin
        frame_byte_index <= (frame_byte_index >= slfd_pkg::FRM_LAST) ? 10'd0
                            : frame_byte_index + 10'd1;
        if (frame_byte_index == 10'd0) begin
          held_bytes[0] <= data_byte;
          adc_idx       <= '0;
          if (fits && header_good) begin
            if (limit_reached || (frame_limit != 32'd0 && frames_done >= frame_limit)) begin
              limit_reached <= 1'b1;
              frame_active  <= 1'b0;
            end else begin
              frame_active <= 1'b1;
            end
          end else begin
            frame_active <= 1'b0;
          end
        end else if (frame_byte_index == 10'd1) begin
          if (frame_active) begin
            if ({data_byte, held_bytes[0]} == slfd_pkg::FRM_MAGIC)
              frames_done <= frames_done + 32'd1;
            else
              frame_active <= 1'b0;
          end
        end else if (frame_byte_index == 10'd2) begin
          held_bytes[2] <= data_byte;
        end else if (frame_byte_index == 10'd3) begin
          imu_in_frame <= {data_byte, held_bytes[2]};
        end else if (frame_byte_index < 10'd7) begin
          held_bytes[frame_byte_index[3:0]] <= data_byte;
        end else if (frame_byte_index == 10'd7) begin
          tick_base <= {data_byte, held_bytes[6], held_bytes[5], held_bytes[4]};
        end else if (frame_byte_index < slfd_pkg::IMU_START) begin
          if (!frame_byte_index[0]) held_bytes[0] <= data_byte;
          else adc_idx <= adc_idx + 8'd1;
        end else if (frame_byte_index < slfd_pkg::IMU_END) begin
          if (r != 4'd15) held_bytes[r] <= data_byte;
        end
      end
    end
  end

  // Capture the header rate
  always_ff @(posedge clk) begin
    if (rst) header_rate <= '0;
    else if (in_fire && in_hdr && byte_position[5:0] == 6'd5)
      header_rate <= {data_byte, held_bytes[4]};
  end

endmodule

// ===== src/slfd_back.sv =====
// ----------------------------------------------------------------------------
// slfd_back
// Two-entry command queue, totals and the registered result stage.
// ----------------------------------------------------------------------------
module slfd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  slfd_pkg::cmd_t     cmd,
  input  logic [15:0]        rate,
  output logic               can_take,
  output logic               out_valid,
  input  logic               out_ready,
  output slfd_pkg::result_t  out_data
);

  slfd_pkg::cmd_t q [2];
  logic [15:0] q_rate [2];
  logic [1:0]  count;
  logic        rd_ptr, wr_ptr;
  logic [31:0] adc_emitted, imu_emitted;
  logic        pop;
  slfd_pkg::cmd_t h;
  slfd_pkg::result_t res_next;
  logic        adc_inc, imu_inc;

  assign can_take = (count != 2'd2);
  assign pop      = (count != 2'd0) && (!out_valid || out_ready);
  assign h        = q[rd_ptr];

  assign adc_inc = (h.kind == slfd_pkg::KIND_ADC) ||
                   (h.kind == slfd_pkg::KIND_SUMM && h.adc_extra);
  assign imu_inc = (h.kind == slfd_pkg::KIND_IMU) ||
                   (h.kind == slfd_pkg::KIND_SUMM && h.imu_extra);

  // Queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (cmd_valid) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, cmd_valid} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid) begin
      q[wr_ptr]      <= cmd;
      q_rate[wr_ptr] <= rate;
    end
  end

  // Drive the output register and count emitted samples
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      adc_emitted <= '0;
      imu_emitted <= '0;
    end else begin
      if (pop) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (pop && adc_inc) adc_emitted <= adc_emitted + 32'd1;
      if (pop && imu_inc) imu_emitted <= imu_emitted + 32'd1;
    end
  end

  // Build the result for the head command
  always_comb begin
    res_next      = '0;
    res_next.kind = h.kind;
    unique case (h.kind)
      slfd_pkg::KIND_ADC: begin
        res_next.sample_tick = h.sample_tick;
        res_next.adc_value   = h.adc_value;
      end
      slfd_pkg::KIND_IMU: begin
        res_next.sample_tick = h.sample_tick;
        res_next.gyro_x  = h.imu[15:0];
        res_next.gyro_y  = h.imu[31:16];
        res_next.gyro_z  = h.imu[47:32];
        res_next.accel_x = h.imu[63:48];
        res_next.accel_y = h.imu[79:64];
        res_next.accel_z = h.imu[95:80];
      end
      slfd_pkg::KIND_SUMM: begin
        if (h.summ_good) begin
          res_next.rate_khz  = q_rate[rd_ptr];
          res_next.adc_total = adc_emitted + {31'd0, h.adc_extra};
          res_next.imu_total = imu_emitted + {31'd0, h.imu_extra};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) out_data <= res_next;
  end

endmodule
